[rtl/chrl_pkg.sv]
// ----------------------------------------------------------------------------
// chrl_pkg - shared types and constants for the hash ring lookup
// Ring depth, field widths, command and status codes, cell interface structs.
// ----------------------------------------------------------------------------
package chrl_pkg;

    localparam int RING_DEPTH = 256;
    localparam int POS_W      = 32;
    localparam int OWNER_W    = 8;
    localparam int CMD_W      = 2;
    localparam int STATUS_W   = 2;

    // OR-reduce grouping: first stage per group, second stage across groups
    localparam int GROUP_SIZE = 64;
    localparam int NUM_GROUPS = (RING_DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic               valid;
        logic [POS_W-1:0]   pos;
        logic [OWNER_W-1:0] owner;
    } point_t;

    // per-cell compare results, held from the compare cycle to the apply cycle
    typedef struct packed {
        logic gt;     // empty, or position above key
        logic gev;    // occupied and position at or above key
        logic match;  // occupied and position equal to key
    } cell_flags_t;

    typedef struct packed {
        logic               cmp_en;
        logic               apply_en;
        logic [CMD_W-1:0]   cmd;
        logic [POS_W-1:0]   key;
        logic [OWNER_W-1:0] who;
        logic               any_match;
        logic               full;
    } cell_ctrl_t;

    typedef struct packed {
        logic               any_first;
        logic               any_match;
        logic [OWNER_W-1:0] owner;
    } reduce_t;

endpackage

[rtl/chrl_cell.sv]
// ----------------------------------------------------------------------------
// chrl_cell - one slot of the sorted ring
// Holds one point, compares it against the broadcast key and shifts with
// its neighbors on insert and remove.
// ----------------------------------------------------------------------------
module chrl_cell
    import chrl_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  cell_ctrl_t         ctrl,
    input  point_t             prev_point,
    input  cell_flags_t        prev_flags,
    input  point_t             next_point,
    output point_t             point,
    output cell_flags_t        flags,
    output logic               first,
    output logic [OWNER_W-1:0] sel_owner
);

    point_t      point_reg;
    point_t      point_next;
    cell_flags_t flags_reg;
    cell_flags_t flags_next;

    always_comb begin
        flags_next.match = point_reg.valid && (point_reg.pos == ctrl.key);
        flags_next.gev   = point_reg.valid && (point_reg.pos >= ctrl.key);
        flags_next.gt    = !point_reg.valid || (point_reg.pos > ctrl.key);
    end

    always_comb begin
        point_next = point_reg;
        if (ctrl.apply_en) begin
            case (ctrl.cmd)
                CMD_INSERT: begin
                    if (ctrl.any_match) begin
                        if (flags_reg.match) begin
                            point_next.owner = ctrl.who;
                        end
                    end else if (!ctrl.full && flags_reg.gt) begin
                        if (prev_flags.gt) begin
                            point_next = prev_point;   // make room: shift up
                        end else begin
                            point_next = '{valid: 1'b1, pos: ctrl.key, owner: ctrl.who};
                        end
                    end
                end
                CMD_REMOVE: begin
                    if (ctrl.any_match && (flags_reg.gt || flags_reg.match)) begin
                        point_next = next_point;       // close the gap: shift down
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // only the valid bit is reset; position and owner are don't-care when empty
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            point_reg.valid <= 1'b0;
        end else begin
            point_reg.valid <= point_next.valid;
        end
        point_reg.pos   <= point_next.pos;
        point_reg.owner <= point_next.owner;
        if (ctrl.cmp_en) begin
            flags_reg <= flags_next;
        end
    end

    // first occupied slot at or above the key (ring is sorted ascending)
    assign first     = flags_reg.gev && !prev_flags.gev;
    assign sel_owner = first ? point_reg.owner : '0;
    assign point     = point_reg;
    assign flags     = flags_reg;

endmodule

[rtl/chrl_reduce.sv]
// ----------------------------------------------------------------------------
// chrl_reduce - two-stage registered OR tree over all cells
// Collects the owner of the first slot at or above the key and the
// match / first flags.
// ----------------------------------------------------------------------------
module chrl_reduce
    import chrl_pkg::*;
(
    input  logic                  aclk,
    input  logic [RING_DEPTH-1:0] first,
    input  logic [RING_DEPTH-1:0] match,
    input  logic [OWNER_W-1:0]    sel_owner [RING_DEPTH],
    output reduce_t               result
);

    reduce_t grp_next [NUM_GROUPS];
    reduce_t grp_reg  [NUM_GROUPS];
    reduce_t top_next;
    reduce_t top_reg;

    always_comb begin
        for (int g = 0; g < NUM_GROUPS; g++) begin
            grp_next[g] = '0;
            for (int k = 0; k < GROUP_SIZE; k++) begin
                if (g * GROUP_SIZE + k < RING_DEPTH) begin
                    grp_next[g].any_first = grp_next[g].any_first | first[g * GROUP_SIZE + k];
                    grp_next[g].any_match = grp_next[g].any_match | match[g * GROUP_SIZE + k];
                    grp_next[g].owner     = grp_next[g].owner | sel_owner[g * GROUP_SIZE + k];
                end
            end
        end
    end

    always_comb begin
        top_next = '0;
        for (int g = 0; g < NUM_GROUPS; g++) begin
            top_next.any_first = top_next.any_first | grp_reg[g].any_first;
            top_next.any_match = top_next.any_match | grp_reg[g].any_match;
            top_next.owner     = top_next.owner | grp_reg[g].owner;
        end
    end

    always_ff @(posedge aclk) begin
        grp_reg <= grp_next;
        top_reg <= top_next;
    end

    assign result = top_reg;

endmodule

[rtl/consistent_hash_ring_lookup.sv]
// ----------------------------------------------------------------------------
// consistent_hash_ring_lookup - sorted ring of hash points with owner lookup
// A chain of cells keeps the points in ascending position order; insert and
// remove shift the chain by one slot, lookup returns the owner of the first
// point at or above the key, wrapping to the lowest point.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: one item per command. s_tuser carries the command
//   (insert, remove, lookup), s_tdata carries the ring position or key and
//   the owner node id for inserts.
//   Result stream m_*: exactly one item per accepted input item, in order.
//   m_tdata carries the owner node, m_tuser the hit flag and status.
// Timing:
//   An item is accepted only when the block is idle. The key is broadcast
//   to all cells and the per-cell flags are registered, the flags go through
//   a two-stage OR tree, then the chain updates and the result register
//   loads. The next item is taken once the block is back in idle after the
//   update, so an item is not taken before the last one is through.
// Reset:
//   aresetn (synchronous, active low) empties the ring and drops any result.
// Stalls:
//   A held result on m_* does not stop the next item from being accepted
//   and worked on; it only waits in the update step until m_tready frees the
//   result register, and the ring does not change until then.
// ----------------------------------------------------------------------------
module consistent_hash_ring_lookup
    import chrl_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [31:0] point_hash, [39:32] node_id
    input  logic [1:0]  s_tuser,   // [1:0] command
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] owner_node
    output logic [2:0]  m_tuser    // [0] hit, [2:1] status
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CMP   = 5'b00010,
        ST_RED1  = 5'b00100,
        ST_RED2  = 5'b01000,
        ST_APPLY = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [CMD_W-1:0]    cmd_reg;
    logic [POS_W-1:0]    key_reg;
    logic [OWNER_W-1:0]  who_reg;

    logic                m_valid_reg, m_valid_next;
    logic [OWNER_W-1:0]  owner_reg, owner_next;
    logic                hit_reg, hit_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    logic                s_fire;
    logic                apply_fire;

    cell_ctrl_t          ctrl;
    point_t              pts      [RING_DEPTH];
    cell_flags_t         flg      [RING_DEPTH];
    logic [OWNER_W-1:0]  sel_own  [RING_DEPTH];
    logic [RING_DEPTH-1:0] first_vec;
    logic [RING_DEPTH-1:0] match_vec;
    reduce_t             red;

    assign s_tready   = (state_reg == ST_IDLE);
    assign s_fire     = s_tvalid && s_tready;
    // the chain only moves once the result has somewhere to go
    assign apply_fire = (state_reg == ST_APPLY) && (!m_valid_reg || m_tready);

    // ---- sequencer ----
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_fire) state_next = ST_CMP;
            ST_CMP:   state_next = ST_RED1;
            ST_RED1:  state_next = ST_RED2;
            ST_RED2:  state_next = ST_APPLY;
            ST_APPLY: if (apply_fire) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            cmd_reg <= s_tuser;
            key_reg <= s_tdata[31:0];
            who_reg <= s_tdata[39:32];
        end
    end

    // ---- cell chain ----
    always_comb begin
        ctrl.cmp_en    = (state_reg == ST_CMP);
        ctrl.apply_en  = apply_fire;
        ctrl.cmd       = cmd_reg;
        ctrl.key       = key_reg;
        ctrl.who       = who_reg;
        ctrl.any_match = red.any_match;
        ctrl.full      = pts[RING_DEPTH-1].valid;
    end

    for (genvar i = 0; i < RING_DEPTH; i++) begin : g_cell
        point_t      prev_pt;
        cell_flags_t prev_fl;
        point_t      next_pt;

        if (i == 0) begin : g_head
            assign prev_pt = '0;
            assign prev_fl = '0;   // no lower neighbor: boundary for insert
        end else begin : g_body
            assign prev_pt = pts[i-1];
            assign prev_fl = flg[i-1];
        end

        if (i == RING_DEPTH - 1) begin : g_tail
            assign next_pt = '0;   // empty slot shifts in at the top
        end else begin : g_mid
            assign next_pt = pts[i+1];
        end

        chrl_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .prev_point (prev_pt),
            .prev_flags (prev_fl),
            .next_point (next_pt),
            .point      (pts[i]),
            .flags      (flg[i]),
            .first      (first_vec[i]),
            .sel_owner  (sel_own[i])
        );

        assign match_vec[i] = flg[i].match;
    end

    chrl_reduce u_reduce (
        .aclk      (aclk),
        .first     (first_vec),
        .match     (match_vec),
        .sel_owner (sel_own),
        .result    (red)
    );

    // ---- result, computed from the ring before this item's update ----
    always_comb begin
        owner_next  = '0;
        hit_next    = 1'b0;
        status_next = STATUS_OK;
        case (cmd_reg)
            CMD_INSERT: begin
                if (!red.any_match && pts[RING_DEPTH-1].valid) begin
                    status_next = STATUS_FULL;
                end
            end
            CMD_LOOKUP: begin
                if (!pts[0].valid) begin
                    status_next = STATUS_EMPTY;
                end else begin
                    hit_next   = 1'b1;
                    // nothing at or above the key: wrap to the lowest point
                    owner_next = red.any_first ? red.owner : pts[0].owner;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (apply_fire) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (apply_fire) begin
            owner_reg  <= owner_next;
            hit_reg    <= hit_next;
            status_reg <= status_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = owner_reg;
    assign m_tuser  = {status_reg, hit_reg};

endmodule
